@@ design/bs_pkg.sv @@
// shared types, sizes and helpers for the bitonic sorter
// no dependencies; imported by bs_ctrl, bs_dp and bitonic_sorter
package bs_pkg;

	localparam int NUM_ELEMENTS = 64;
	localparam int STORE_DEPTH  = 64;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = $clog2(STORE_DEPTH);
	localparam int BANK_DEPTH   = STORE_DEPTH / 2;
	localparam int BANK_AW      = IDX_W - 1;
	localparam int PAIR_W       = IDX_W - 1;
	localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
	localparam int LG_W         = $clog2(IDX_W + 1);
	localparam int LG_P         = $clog2(NUM_ELEMENTS);
	localparam int PAD_SIZE     = 1 << LG_P;

	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [PAIR_W-1:0]        pair_t;
	typedef logic [LG_W-1:0]          lg_t;
	typedef logic [BANK_AW-1:0]       baddr_t;
	typedef logic signed [DATA_W-1:0] data_t;

	localparam data_t PAD_VALUE = {1'b0, {(DATA_W-1){1'b1}}};

	// command word from controller to datapath
	typedef struct packed {
		logic wr_en;
		logic wr_pad;
		idx_t wr_idx;
		logic cs_en;
		idx_t cs_lo;
		idx_t cs_hi;
		logic cs_desc;
		logic out_en;
		idx_t out_idx;
		logic out_last;
	} bs_cmd_t;

	// the two indices of a pair differ in one bit, so parity splits them over two banks
	function automatic logic bank_of(input idx_t idx);
		return ^idx;
	endfunction

	function automatic baddr_t bank_addr(input idx_t idx);
		return idx[IDX_W-1:1];
	endfunction

	// lower index of a pair: insert a zero at the stride bit position
	function automatic idx_t pair_lo(input pair_t pair, input lg_t str_lg);
		idx_t p;
		idx_t mask;
		p    = {1'b0, pair};
		mask = ~({IDX_W{1'b1}} << str_lg);
		return ((p & ~mask) << 1) | (p & mask);
	endfunction

endpackage

@@ design/bs_ctrl.sv @@
// sequencer for the bitonic sorter: load, pad, network stages, burst out
// depends on bs_pkg; drives the bs_dp command word
module bs_ctrl
	import bs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output bs_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_SORT,
		S_DRAIN,
		S_EMIT
	} state_t;

	localparam pair_t LAST_PAIR = pair_t'(PAD_SIZE / 2 - 1);
	localparam lg_t   TOP_LG    = lg_t'(LG_P);

	state_t           state_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	pair_t            pair_q;
	lg_t              blk_q;
	lg_t              str_q;
	logic             done_q;
	logic             accept;
	idx_t             lo;
	logic [IDX_W:0]   lo_shift;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			pair_q  <= '0;
			blk_q   <= lg_t'(1);
			str_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(NUM_ELEMENTS - 1)) begin
							busy_q  <= 1'b1;
							state_q <= (NUM_ELEMENTS == PAD_SIZE) ? S_SORT : S_PAD;
						end
					end
				end
				S_PAD: begin
					if (cnt_q == CNT_W'(PAD_SIZE - 1)) begin
						state_q <= S_SORT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SORT: begin
					pair_q <= pair_q + 1'b1;
					if (pair_q == LAST_PAIR) begin
						pair_q  <= '0;
						state_q <= S_DRAIN;
						if (str_q == '0) begin
							if (blk_q == TOP_LG) begin
								done_q <= 1'b1;
							end else begin
								blk_q <= blk_q + 1'b1;
								str_q <= blk_q;
							end
						end else begin
							str_q <= str_q - 1'b1;
						end
					end
				end
				S_DRAIN: begin
					// bubble state so the last write-back lands before the next read
					if (done_q) begin
						done_q  <= 1'b0;
						blk_q   <= lg_t'(1);
						str_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SORT;
					end
				end
				S_EMIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_ELEMENTS - 1)) begin
						cnt_q   <= '0;
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign lo       = pair_lo(pair_q, str_q);
	assign lo_shift = {1'b0, lo} >> blk_q;

	always_comb begin
		cmd          = '0;
		cmd.wr_en    = accept || (state_q == S_PAD);
		cmd.wr_pad   = (state_q == S_PAD);
		cmd.wr_idx   = cnt_q[IDX_W-1:0];
		cmd.cs_en    = (state_q == S_SORT);
		cmd.cs_lo    = lo;
		cmd.cs_hi    = lo | (idx_t'(1) << str_q);
		cmd.cs_desc  = lo_shift[0];
		cmd.out_en   = (state_q == S_EMIT);
		cmd.out_idx  = cnt_q[IDX_W-1:0];
		cmd.out_last = (cnt_q == CNT_W'(NUM_ELEMENTS - 1));
	end

endmodule

@@ design/bs_dp.sv @@
// datapath of the bitonic sorter: two parity banks, compare-swap, output select
// depends on bs_pkg; commanded by bs_ctrl
module bs_dp
	import bs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  bs_cmd_t cmd,
	input  data_t   value,
	output logic    strobe,
	output data_t   sorted_value,
	output logic    last
);

	data_t  mem0_q [BANK_DEPTH];
	data_t  mem1_q [BANK_DEPTH];
	data_t  rdata0_s1;
	data_t  rdata1_s1;

	logic   cs_v_s1;
	logic   out_v_s1;
	idx_t   lo_s1;
	idx_t   hi_s1;
	logic   desc_s1;
	logic   last_s1;
	logic   obank_s1;

	logic   we0, we1;
	baddr_t wa0, wa1, ra0, ra1;
	data_t  wd0, wd1;
	data_t  a, b, new_lo, new_hi;
	logic   swap, blo_s1, blo, wbank;
	data_t  ld_data;

	assign blo     = bank_of(cmd.cs_lo);
	assign blo_s1  = bank_of(lo_s1);
	assign wbank   = bank_of(cmd.wr_idx);
	assign ld_data = cmd.wr_pad ? PAD_VALUE : value;

	assign a      = blo_s1 ? rdata1_s1 : rdata0_s1;
	assign b      = blo_s1 ? rdata0_s1 : rdata1_s1;
	assign swap   = desc_s1 ? (b > a) : (a > b);
	assign new_lo = swap ? b : a;
	assign new_hi = swap ? a : b;

	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wa0 = bank_addr(cmd.wr_idx);
		wa1 = bank_addr(cmd.wr_idx);
		wd0 = ld_data;
		wd1 = ld_data;
		if (cs_v_s1) begin
			we0 = 1'b1;
			we1 = 1'b1;
			wa0 = blo_s1 ? bank_addr(hi_s1) : bank_addr(lo_s1);
			wa1 = blo_s1 ? bank_addr(lo_s1) : bank_addr(hi_s1);
			wd0 = blo_s1 ? new_hi : new_lo;
			wd1 = blo_s1 ? new_lo : new_hi;
		end else if (cmd.wr_en) begin
			we0 = !wbank;
			we1 = wbank;
		end
	end

	always_comb begin
		if (cmd.cs_en) begin
			ra0 = blo ? bank_addr(cmd.cs_hi) : bank_addr(cmd.cs_lo);
			ra1 = blo ? bank_addr(cmd.cs_lo) : bank_addr(cmd.cs_hi);
		end else begin
			ra0 = bank_addr(cmd.out_idx);
			ra1 = bank_addr(cmd.out_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0_q[wa0] <= wd0;
		end
		if (we1) begin
			mem1_q[wa1] <= wd1;
		end
		rdata0_s1 <= mem0_q[ra0];
		rdata1_s1 <= mem1_q[ra1];
		lo_s1     <= cmd.cs_lo;
		hi_s1     <= cmd.cs_hi;
		desc_s1   <= cmd.cs_desc;
		last_s1   <= cmd.out_last;
		obank_s1  <= bank_of(cmd.out_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_v_s1  <= 1'b0;
			out_v_s1 <= 1'b0;
		end else begin
			cs_v_s1  <= cmd.cs_en;
			out_v_s1 <= cmd.out_en;
		end
	end

	assign strobe       = out_v_s1;
	assign sorted_value = obank_s1 ? rdata1_s1 : rdata0_s1;
	assign last         = out_v_s1 && last_s1;

endmodule

@@ design/bitonic_sorter.sv @@
// bitonic sorter top level: controller plus datapath
// depends on bs_pkg, bs_ctrl, bs_dp
//
// Load NUM_ELEMENTS signed values one per cycle with start while busy is low.
// On the last value busy rises; slots up to the next power of two P are filled
// with the largest signed value, then the network runs log2(P)*(log2(P)+1)/2
// stages, each of P/2 compare-swaps then a drain bubble, one compare-swap per cycle
// on two parity-split store banks with one read and one write port each. The
// sorted set then comes out ascending, one value per cycle on strobe with last
// on the final one; there is no back-pressure, so the receiver must take every
// cycle of the burst. The next set may be loaded from the cycle that carries
// the final element.
module bitonic_sorter
	import bs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  data_t value,
	output logic  strobe,
	output data_t sorted_value,
	output logic  last
);

	bs_cmd_t cmd;

	bs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	bs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.last         (last)
	);

endmodule

@@ design/bs_checker.sv @@
// port-level checks on the output burst of the bitonic sorter
// no package needed; bound to bitonic_sorter below
module bs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        strobe,
	input logic [31:0] sorted_value,
	input logic        last
);

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last without strobe");

	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside sorted burst");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !strobe)
		else $error("strobe continues after last");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy || last)
		else $error("result while idle");

	a_value_known: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !$isunknown(sorted_value))
		else $error("unknown sorted value on strobe");

endmodule

bind bitonic_sorter bs_checker u_bs_checker (.*);

@@ verif/bitonic_sorter_test.sv @@
// testbench for bitonic_sorter: loads sets of signed values and checks each sorted burst
// depends on bs_pkg and the bitonic_sorter design; self-contained otherwise
module bitonic_sorter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_N       = bs_pkg::NUM_ELEMENTS;
	localparam int NET_N       = 1 << $clog2(SET_N);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_REPORTS = 10;

	typedef bs_pkg::data_t data_t;

	typedef struct packed {
		data_t elem;
		logic  last;
	} sorted_elem_t;

	typedef enum int {
		FILL_UNIFORM,
		FILL_NARROW,
		FILL_EXTREMES,
		FILL_RAMP
	} fill_kind_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  start;
	logic  busy;
	data_t value;
	logic  strobe;
	data_t sorted_value;
	logic  last;

	// values of the set being loaded, padded up to the network size when it closes
	data_t        set_buf [NET_N];
	int           set_fill;
	sorted_elem_t sorted_q [$];
	int           error_count;
	int           cycle_count;
	bit           gaps_on;

	bitonic_sorter i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.last        (last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// stores one value; once the set is closed, runs the compare-swap network and queues the ascending burst
	function automatic void record_value(data_t v);
		data_t        a;
		data_t        b;
		logic         desc;
		int           j;
		sorted_elem_t e;
		set_buf[set_fill] = v;
		set_fill++;
		if (set_fill < SET_N)
			return;
		for (int i = SET_N; i < NET_N; i++)
			set_buf[i] = 32'sh7FFF_FFFF;
		for (int blk = 2; blk <= NET_N; blk <<= 1) begin
			for (int str = blk / 2; str >= 1; str >>= 1) begin
				for (int i = 0; i < NET_N; i++) begin
					j = i + str;
					if ((i & str) == 0 && j < NET_N) begin
						desc = (i & blk) != 0;
						a = set_buf[i];
						b = set_buf[j];
						if (desc ? (b > a) : (a > b)) begin
							set_buf[i] = b;
							set_buf[j] = a;
						end
					end
				end
			end
		end
		for (int k = 0; k < SET_N; k++) begin
			e.elem = set_buf[k];
			e.last = (k == SET_N - 1);
			sorted_q.push_back(e);
		end
		set_fill = 0;
	endfunction

	always @(posedge clk) begin : check_results
		sorted_elem_t exp_e;
		if (arst_n && strobe) begin
			if (sorted_q.size() == 0) begin
				note_failure($sformatf("unexpected result %0d last %b", sorted_value, last));
			end else begin
				exp_e = sorted_q.pop_front();
				if (exp_e.elem !== sorted_value || exp_e.last !== last)
					note_failure($sformatf("expected %0d last %b, got %0d last %b",
						exp_e.elem, exp_e.last, sorted_value, last));
			end
		end
	end

	// mostly short gaps, some long ones
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// one transaction: hold start until busy is low at a rising edge, then, if a gap is picked, drop start and idle
	task automatic send_value(data_t v);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		record_value(v);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			value <= data_t'($urandom);
			repeat (gap - 1) begin
				@(negedge clk);
				value <= data_t'($urandom);
			end
		end
	endtask

	task automatic test_walking_bits();
		gaps_on = 1'b0;
		for (int i = 0; i < SET_N; i++) begin
			if (i < 32)
				send_value(data_t'(32'h1 << i));
			else
				send_value(data_t'(~(32'h1 << (i - 32))));
		end
	endtask

	task automatic test_extreme_ties();
		data_t pool [5];
		pool = '{32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0, -32'sh1, 32'sh8000_0000};
		gaps_on = 1'b1;
		for (int i = 0; i < SET_N; i++)
			send_value(pool[i % 5]);
	endtask

	task automatic test_reverse_order();
		gaps_on = 1'b1;
		for (int i = 0; i < SET_N; i++)
			send_value(data_t'((SET_N / 2 - i) * 32'sd1000003));
	endtask

	function automatic data_t random_value(fill_kind_t kind, int idx);
		case (kind)
			FILL_UNIFORM:  return data_t'($urandom);
			FILL_NARROW:   return data_t'($urandom_range(0, 7)) - 32'sd4;
			FILL_EXTREMES: begin
				case ($urandom_range(0, 3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7FFF_FFFF;
					2:       return data_t'($urandom_range(0, 2)) - 32'sd1;
					default: return data_t'($urandom);
				endcase
			end
			default:       return data_t'(idx * 32'sd65537) + data_t'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic test_random_sets();
		fill_kind_t kind;
		for (int s = 0; s < 2; s++) begin
			kind = fill_kind_t'($urandom_range(0, 3));
			gaps_on = ($urandom_range(0, 2) != 0);
			for (int i = 0; i < SET_N; i++)
				send_value(random_value(kind, ($urandom_range(0, 1) != 0) ? i : SET_N - i));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		value       = '0;
		set_fill    = 0;
		error_count = 0;
		cycle_count = 0;
		gaps_on     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_walking_bits();
		test_extreme_ties();
		test_reverse_order();
		test_random_sets();

		@(negedge clk);
		start <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
design/bs_pkg.sv
design/bs_ctrl.sv
design/bs_dp.sv
design/bitonic_sorter.sv
design/bs_checker.sv
verif/bitonic_sorter_test.sv
